### rtl/ccfr_pkg.sv
// Shared types and constants for the CAN command frame reassembler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ccfr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // result status codes
  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_HELD     = 3'd1;
  localparam logic [2:0] ST_QUEUED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NO_HDR   = 3'd4;
  localparam logic [2:0] ST_POPPED   = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  // command type codes
  localparam logic [7:0] CT_WRITE        = 8'd0;
  localparam logic [7:0] CT_REQUEST      = 8'd1;
  localparam logic [7:0] CT_WRITE_ADDR   = 8'd2;
  localparam logic [7:0] CT_REQUEST_ADDR = 8'd3;

  // item command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_POP   = 1'b1;

  typedef struct packed {
    logic        command;
    logic [10:0] frame_id;
    logic        remote_request;
    logic [6:0]  frame_length;
    logic [63:0] payload_word0;
    logic [63:0] payload_word1;
    logic [63:0] payload_word2;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  cmd_type;
    logic [15:0] class_id;
    logic [7:0]  instance_no;
    logic [31:0] cmd_id;
    logic [63:0] cmd_value;
    logic [63:0] cmd_address;
    logic [3:0]  queue_level;
    logic [31:0] drop_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic step;
  } ctl_cmd_t;

endpackage

### rtl/ccfr_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on ccfr_pkg for the payload types.
`timescale 1ns / 1ps

interface ccfr_in_if import ccfr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccfr_out_if import ccfr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/ccfr_ctrl.sv
// Handshake controller: accepts an item when the result register is free
// or being drained, and holds the result until it is taken. Uses ccfr_pkg.
`timescale 1ns / 1ps

module ccfr_ctrl
  import ccfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state;
  logic state_next;

  assign out_valid = (state == S_HOLD);
  assign in_ready  = (state == S_IDLE) || out_ready;
  assign cmd.step  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.step) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (cmd.step) state_next = S_HOLD;
        else if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

### rtl/ccfr_datapath.sv
// Datapath: pending command registers, command ring, drop counter and the
// result register. Advances one item per step command. Uses ccfr_pkg.
`timescale 1ns / 1ps

module ccfr_datapath
  import ccfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  input  in_item_t    in_data,
  output out_item_t   out_data
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(QUEUE_DEPTH);

  logic [10:0] base_id;
  logic        hdr_seen, val_seen, adr_seen;
  logic [63:0] pend_header, pend_value, pend_address;
  logic [PTR_W-1:0] ring_head, ring_tail;
  logic [31:0] drops;

  logic [63:0] ring_header [QUEUE_DEPTH];
  logic [63:0] ring_value [QUEUE_DEPTH];
  logic [63:0] ring_address [QUEUE_DEPTH];

  logic        frame_ok, is_hdr, is_val, is_adr;
  logic [11:0] id_x, base_x;
  logic        c_hdr, c_val, c_adr;
  logic [63:0] c_header, c_value, c_address;
  logic        need_val, need_adr, complete;
  logic [PTR_W-1:0] tail_inc, head_inc;
  logic        empty, full;
  logic        do_push, do_pop, do_drop, upd_pend, clr_pend;
  logic [2:0]  status;
  logic [PTR_W-1:0] head_next, tail_next, level;
  logic [31:0] drops_next;

  assign frame_ok = (in_data.command == CMD_FRAME) && !in_data.remote_request
                    && (in_data.frame_length >= 7'd8);
  assign id_x   = {1'b0, in_data.frame_id};
  assign base_x = {1'b0, base_id};
  // no wrap on base+1 and base+2: a high base leaves them unmatched
  assign is_hdr = frame_ok && (id_x == base_x);
  assign is_val = frame_ok && (id_x == base_x + 12'd1);
  assign is_adr = frame_ok && (id_x == base_x + 12'd2);

  // candidate pending command after this frame
  always_comb begin
    c_hdr     = hdr_seen;
    c_val     = val_seen;
    c_adr     = adr_seen;
    c_header  = pend_header;
    c_value   = pend_value;
    c_address = pend_address;
    if (is_hdr) begin
      c_hdr     = 1'b1;
      c_header  = in_data.payload_word0;
      c_val     = (in_data.frame_length >= 7'd16);
      c_value   = c_val ? in_data.payload_word1 : 64'd0;
      c_adr     = (in_data.frame_length >= 7'd24);
      c_address = c_adr ? in_data.payload_word2 : 64'd0;
    end else if (is_val) begin
      c_val   = 1'b1;
      c_value = in_data.payload_word0;
    end else if (is_adr) begin
      c_adr     = 1'b1;
      c_address = in_data.payload_word0;
    end
  end

  assign need_val = (c_header[7:0] == CT_WRITE) || (c_header[7:0] == CT_WRITE_ADDR);
  assign need_adr = (c_header[7:0] == CT_WRITE_ADDR) || (c_header[7:0] == CT_REQUEST_ADDR);
  assign complete = c_hdr && (!need_val || c_val) && (!need_adr || c_adr);

  assign tail_inc = (ring_tail == PTR_LAST) ? '0 : ring_tail + 1'b1;
  assign head_inc = (ring_head == PTR_LAST) ? '0 : ring_head + 1'b1;
  assign empty    = (ring_head == ring_tail);
  assign full     = (tail_inc == ring_head);

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_drop  = 1'b0;
    upd_pend = 1'b0;
    clr_pend = 1'b0;
    status   = ST_IGNORED;
    priority if (in_data.command == CMD_POP) begin
      if (empty) begin
        status = ST_EMPTY;
      end else begin
        status = ST_POPPED;
        do_pop = 1'b1;
      end
    end else if (is_hdr || ((is_val || is_adr) && hdr_seen)) begin
      if (complete) begin
        clr_pend = 1'b1;
        if (full) begin
          do_drop = 1'b1;
          status  = ST_FULL;
        end else begin
          do_push = 1'b1;
          status  = ST_QUEUED;
        end
      end else begin
        upd_pend = 1'b1;
        status   = ST_HELD;
      end
    end else if (is_val || is_adr) begin
      do_drop = 1'b1;
      status  = ST_NO_HDR;
    end else begin
      // remote, short or foreign frame: leave the state unchanged
      status = ST_IGNORED;
    end
  end

  assign head_next  = do_pop ? head_inc : ring_head;
  assign tail_next  = do_push ? tail_inc : ring_tail;
  assign drops_next = do_drop ? drops + 32'd1 : drops;

  always_comb begin
    if (tail_next >= head_next) level = tail_next - head_next;
    else level = PTR_W'(DEPTH_X + {1'b0, tail_next} - {1'b0, head_next});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id      <= '0;
      hdr_seen     <= 1'b0;
      val_seen     <= 1'b0;
      adr_seen     <= 1'b0;
      pend_header  <= '0;
      pend_value   <= '0;
      pend_address <= '0;
      ring_head    <= '0;
      ring_tail    <= '0;
      drops        <= '0;
    end else begin
      if (cfg_we) base_id <= cfg_data;
      if (cmd.step) begin
        ring_head <= head_next;
        ring_tail <= tail_next;
        drops     <= drops_next;
        if (clr_pend) begin
          hdr_seen     <= 1'b0;
          val_seen     <= 1'b0;
          adr_seen     <= 1'b0;
          pend_header  <= '0;
          pend_value   <= '0;
          pend_address <= '0;
        end else if (upd_pend) begin
          hdr_seen     <= c_hdr;
          val_seen     <= c_val;
          adr_seen     <= c_adr;
          pend_header  <= c_header;
          pend_value   <= c_value;
          pend_address <= c_address;
        end
      end
    end
  end

  // ring storage: write at tail
  always_ff @(posedge clk) begin
    if (cmd.step && do_push) begin
      ring_header[ring_tail]  <= c_header;
      ring_value[ring_tail]   <= c_value;
      ring_address[ring_tail] <= c_address;
    end
  end

  // result register; the ring read at head lands here
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data.status      <= status;
      out_data.queue_level <= 4'(level);
      out_data.drop_count  <= drops_next;
      if (do_pop) begin
        out_data.cmd_type    <= ring_header[ring_head][7:0];
        out_data.class_id    <= ring_header[ring_head][23:8];
        out_data.instance_no <= ring_header[ring_head][31:24];
        out_data.cmd_id      <= ring_header[ring_head][63:32];
        out_data.cmd_value   <= ring_value[ring_head];
        out_data.cmd_address <= ring_address[ring_head];
      end else begin
        out_data.cmd_type    <= '0;
        out_data.class_id    <= '0;
        out_data.instance_no <= '0;
        out_data.cmd_id      <= '0;
        out_data.cmd_value   <= '0;
        out_data.cmd_address <= '0;
      end
    end
  end

endmodule

### rtl/can_command_frame_reassembler.sv
// CAN command frame reassembler, top level.
// An accepted item's result is in the result register in the following cycle.
// Throughput: one item per cycle while out_ready holds; the register frees when taken.
// Reset (rst, synchronous): clears base_id, pending parts, ring pointers and drop count.
// Ring slots are not cleared; only written slots are ever read.
`timescale 1ns / 1ps

module can_command_frame_reassembler
  import ccfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  ccfr_in_if.sink     item,
  ccfr_out_if.source  result
);

  ctl_cmd_t cmd;

  ccfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  ccfr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (item.data),
    .out_data (result.data)
  );

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> result.valid)
    else $error("accepted transaction produced no result");

  a_stall_only_on_hold: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (result.valid && !result.ready))
    else $error("input stalled while result register free");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.status != ST_POPPED) |->
      (result.data.cmd_value == 64'd0 && result.data.cmd_address == 64'd0))
    else $error("non-pop result carries payload");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for can_command_frame_reassembler.
// Needs ccfr_pkg and the ccfr_in_if / ccfr_out_if interfaces from the rtl folder.
// Predicts results from a model of the pending parts and ring, unless a row types its own.
`timescale 1ns / 1ps

module tb_top;
  import ccfr_pkg::*;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [10:0] cfg_data;

  ccfr_in_if  item_ch ();
  ccfr_out_if res_ch ();

  can_command_frame_reassembler dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (res_ch)
  );

  // predicted block state
  logic [10:0]      base_reg = '0;
  bit               hdr_ok, val_ok, adr_ok;
  logic [63:0]      pend_hdr = '0;
  logic [63:0]      pend_val = '0;
  logic [63:0]      pend_adr = '0;
  logic [63:0]      ring_hdr [QUEUE_DEPTH];
  logic [63:0]      ring_val [QUEUE_DEPTH];
  logic [63:0]      ring_adr [QUEUE_DEPTH];
  logic [PTR_W-1:0] head = '0;
  logic [PTR_W-1:0] tail = '0;
  logic [31:0]      drops = '0;

  out_item_t due_results [$];
  stim_row_t dir_rows [$];
  bit        row_typed;
  out_item_t row_want;
  bit        tx_calm, rx_calm;
  int        n_accepted, n_effective, n_results, n_errors;
  int        status_hits [8];

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[can_command_frame_reassembler] ERROR");
    $finish;
  end

  task automatic report(input string msg);
    if (n_errors < 50) $display("[tb] mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", n_results, name, got, want));
  endtask

  function automatic void add_row(input stim_row_t s);
    dir_rows = {dir_rows, s};
  endfunction

  function automatic void clear_parts();
    hdr_ok   = 1'b0;
    val_ok   = 1'b0;
    adr_ok   = 1'b0;
    pend_hdr = '0;
    pend_val = '0;
    pend_adr = '0;
  endfunction

  // Queue the pending command once its type has every part it needs; count a drop if the ring is full.
  function automatic logic [2:0] commit_if_complete();
    logic [7:0] kind;
    logic       need_val, need_adr;
    logic [2:0] st;
    kind     = pend_hdr[7:0];
    need_val = (kind == CT_WRITE) || (kind == CT_WRITE_ADDR);
    need_adr = (kind == CT_WRITE_ADDR) || (kind == CT_REQUEST_ADDR);
    if (!hdr_ok || (need_val && !val_ok) || (need_adr && !adr_ok)) return ST_HELD;
    if (PTR_W'(tail + 1'b1) == head) begin
      drops = drops + 1'b1;
      st    = ST_FULL;
    end else begin
      ring_hdr[tail] = pend_hdr;
      ring_val[tail] = pend_val;
      ring_adr[tail] = pend_adr;
      tail           = tail + 1'b1;
      st             = ST_QUEUED;
    end
    clear_parts();
    return st;
  endfunction

  function automatic out_item_t reassemble(input in_item_t it);
    out_item_t r;
    int        id_i, base_i;
    r      = '0;
    id_i   = it.frame_id;
    base_i = base_reg;
    r.status = ST_IGNORED;
    if (it.command == CMD_POP) begin
      if (head == tail) begin
        r.status = ST_EMPTY;
      end else begin
        r.cmd_type    = ring_hdr[head][7:0];
        r.class_id    = ring_hdr[head][23:8];
        r.instance_no = ring_hdr[head][31:24];
        r.cmd_id      = ring_hdr[head][63:32];
        r.cmd_value   = ring_val[head];
        r.cmd_address = ring_adr[head];
        head          = head + 1'b1;
        r.status      = ST_POPPED;
      end
    end else if (!it.remote_request && it.frame_length >= 8) begin
      // base+1 and base+2 are compared without wrap
      if (id_i == base_i) begin
        clear_parts();
        hdr_ok   = 1'b1;
        pend_hdr = it.payload_word0;
        if (it.frame_length >= 16) begin
          pend_val = it.payload_word1;
          val_ok   = 1'b1;
        end
        if (it.frame_length >= 24) begin
          pend_adr = it.payload_word2;
          adr_ok   = 1'b1;
        end
        r.status = commit_if_complete();
      end else if (id_i == base_i + 1 || id_i == base_i + 2) begin
        if (!hdr_ok) begin
          drops    = drops + 1'b1;
          r.status = ST_NO_HDR;
        end else begin
          if (id_i == base_i + 1) begin
            pend_val = it.payload_word0;
            val_ok   = 1'b1;
          end else begin
            pend_adr = it.payload_word0;
            adr_ok   = 1'b1;
          end
          r.status = commit_if_complete();
        end
      end
    end
    r.queue_level = 4'(tail - head);
    r.drop_count  = drops;
    return r;
  endfunction

  // Predict at acceptance; a directed row may carry its own typed-in result.
  always @(posedge clk) begin : accept_mon
    out_item_t p;
    if (!rst && item_ch.valid && item_ch.ready) begin
      p = reassemble(item_ch.data);
      if (p.status != ST_IGNORED) n_effective++;
      due_results = {due_results, row_typed ? row_want : p};
      n_accepted++;
    end
  end

  always @(posedge clk) begin : result_chk
    out_item_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = due_results.pop_front();
        check("status", 64'(got.status), 64'(want.status));
        check("cmd_type", 64'(got.cmd_type), 64'(want.cmd_type));
        check("class_id", 64'(got.class_id), 64'(want.class_id));
        check("instance_no", 64'(got.instance_no), 64'(want.instance_no));
        check("cmd_id", 64'(got.cmd_id), 64'(want.cmd_id));
        check("cmd_value", got.cmd_value, want.cmd_value);
        check("cmd_address", got.cmd_address, want.cmd_address);
        check("queue_level", 64'(got.queue_level), 64'(want.queue_level));
        check("drop_count", 64'(got.drop_count), 64'(want.drop_count));
        status_hits[want.status]++;
      end
      n_results++;
    end
  end

  function automatic int next_delay(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Result side: before taking each transaction, hold ready low for a random stall that may be zero.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = next_delay(rx_calm);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t mk_frame(input logic [10:0] id, input logic rtr,
                                        input logic [6:0] len, input logic [63:0] w0,
                                        input logic [63:0] w1, input logic [63:0] w2);
    in_item_t it;
    it.command        = CMD_FRAME;
    it.frame_id       = id;
    it.remote_request = rtr;
    it.frame_length   = len;
    it.payload_word0  = w0;
    it.payload_word1  = w1;
    it.payload_word2  = w2;
    return it;
  endfunction

  // Frame fields of a pop are junk and must be ignored.
  function automatic in_item_t mk_pop();
    in_item_t it;
    it         = mk_frame(11'($urandom), 1'($urandom), 7'($urandom),
                          rand_word(), rand_word(), rand_word());
    it.command = CMD_POP;
    return it;
  endfunction

  function automatic stim_row_t row(input in_item_t it);
    stim_row_t s;
    s.it    = it;
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  function automatic stim_row_t row_exp(input in_item_t it, input logic [2:0] st,
                                        input int lvl, input int drp);
    stim_row_t s;
    s                  = row(it);
    s.typed            = 1'b1;
    s.want.status      = st;
    s.want.queue_level = 4'(lvl);
    s.want.drop_count  = 32'(drp);
    return s;
  endfunction

  task automatic send(input in_item_t it, input bit typed = 1'b0, input out_item_t want = '0);
    int gap;
    gap = next_delay(tx_calm);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Hold the sender until every expected result is back, then let the pipe drain.
  task automatic settle();
    int guard;
    guard = 0;
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_base(input logic [10:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_reg = v;
  endtask

  task automatic send_part(input int offset);
    int reps;
    // drop the part now and then to leave a broken sequence behind
    if ($urandom_range(0, 11) == 0) return;
    if ($urandom_range(0, 7) == 0) send(mk_pop());
    reps = ($urandom_range(0, 5) == 0) ? 2 : 1;
    repeat (reps)
      send(mk_frame(11'(base_reg + offset), 1'b0,
                    ($urandom_range(0, 9) == 0) ? 7'd127 : 7'($urandom_range(8, 64)),
                    rand_word(), rand_word(), rand_word()));
  endtask

  task automatic send_sequence();
    logic [7:0]  kind;
    logic [63:0] w0;
    int          len;
    bit          need_val, need_adr, val_first;
    kind = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    case ($urandom_range(0, 2))
      0:       len = $urandom_range(8, 15);
      1:       len = $urandom_range(16, 23);
      default: len = ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(24, 64);
    endcase
    w0       = rand_word();
    w0[7:0]  = kind;
    send(mk_frame(base_reg, 1'b0, 7'(len), w0, rand_word(), rand_word()));
    need_val  = (kind == CT_WRITE || kind == CT_WRITE_ADDR) && len < 16;
    need_adr  = (kind == CT_WRITE_ADDR || kind == CT_REQUEST_ADDR) && len < 24;
    val_first = 1'($urandom_range(0, 1));
    if (need_adr && !val_first) send_part(2);
    if (need_val) send_part(1);
    if (need_adr && val_first) send_part(2);
  endtask

  task automatic send_noise();
    logic [10:0] id;
    case ($urandom_range(0, 3))
      0:       id = base_reg;
      1:       id = base_reg + 11'd1;
      2:       id = base_reg + 11'd2;
      default: id = 11'($urandom_range(0, 2047));
    endcase
    send(mk_frame(id, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                  rand_word(), rand_word(), rand_word()));
  endtask

  initial begin
    logic [10:0] bases [6];
    int          pop_pct [6];
    int          target, pick;

    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    row_typed     <= 1'b0;
    row_want      <= '0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, base 0 from reset: header id 0, value id 1, address id 2
    add_row(row_exp(mk_pop(), ST_EMPTY, 0, 0));
    add_row(row_exp(mk_frame(11'd1, 1'b0, 7'd8, '1, '0, '0), ST_NO_HDR, 0, 1));
    add_row(row_exp(mk_frame(11'd2, 1'b0, 7'd64, '0, '1, '1), ST_NO_HDR, 0, 2));
    add_row(row_exp(mk_frame(11'd0, 1'b1, 7'd8, '1, '1, '1), ST_IGNORED, 0, 2));
    add_row(row_exp(mk_frame(11'd0, 1'b0, 7'd7, '1, '1, '1), ST_IGNORED, 0, 2));
    add_row(row_exp(mk_frame(11'd2047, 1'b0, 7'd8, '1, '1, '1), ST_IGNORED, 0, 2));
    add_row(row_exp(mk_frame(11'd0, 1'b0, 7'd8,
                             {32'hFFFF_FFFF, 8'hFF, 16'hFFFF, CT_REQUEST}, '0, '0),
                    ST_QUEUED, 1, 2));
    add_row(row_exp(mk_frame(11'd0, 1'b0, 7'd8,
                             {32'h1234_5678, 8'h05, 16'hABCD, CT_WRITE}, '1, '1),
                    ST_HELD, 1, 2));
    add_row(row_exp(mk_frame(11'd1, 1'b0, 7'd8, '1, '0, '0), ST_QUEUED, 2, 2));
    add_row(row(mk_frame(11'd0, 1'b0, 7'd16,
                         {32'hCAFE_0001, 8'h02, 16'h0100, CT_WRITE_ADDR},
                         rand_word(), rand_word())));
    // repeated value overwrites the first
    add_row(row(mk_frame(11'd1, 1'b0, 7'd12, rand_word(), '0, '0)));
    // new header while one is pending: discard the old one without a drop
    add_row(row(mk_frame(11'd0, 1'b0, 7'd8,
                         {32'h0000_0042, 8'hFF, 16'h0002, CT_REQUEST_ADDR},
                         rand_word(), rand_word())));
    add_row(row(mk_frame(11'd2, 1'b0, 7'd8, rand_word(), '1, '1)));
    add_row(row(mk_frame(11'd0, 1'b0, 7'd24,
                         {56'hFF_FFFF_FFFF_FFFF, CT_WRITE_ADDR}, '1, '1)));
    add_row(row(mk_frame(11'd0, 1'b0, 7'd127, {56'h0, 8'hFF}, '0, '0)));
    add_row(row(mk_frame(11'd0, 1'b0, 7'd23,
                         {32'h8000_0000, 8'h00, 16'h8000, CT_WRITE_ADDR},
                         rand_word(), rand_word())));
    add_row(row(mk_frame(11'd2, 1'b1, 7'd8, '1, '1, '1)));
    add_row(row(mk_frame(11'd2, 1'b0, 7'd8, '0, '1, '1)));
    repeat (6) add_row(row(mk_pop()));
    add_row(row_exp(mk_pop(), ST_EMPTY, 0, 2));

    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // random part: one phase per base setting, pop weight varies to fill and drain the ring
    bases   = '{11'd2045, 11'($urandom_range(0, 2047)), 11'd2047, 11'd2046,
                11'($urandom_range(0, 2047)), 11'd0};
    pop_pct = '{5, 45, 20, 35, 8, 30};
    foreach (bases[ph]) begin
      settle();
      set_base(bases[ph]);
      target = n_accepted + 170;
      while (n_accepted < target) begin
        pick = $urandom_range(0, 99);
        if (pick < pop_pct[ph]) send(mk_pop());
        else if (pick < pop_pct[ph] + (100 - pop_pct[ph]) * 4 / 5) send_sequence();
        else send_noise();
        if ($urandom_range(0, 149) == 0) settle();
      end
    end

    settle();
    if (due_results.size() != 0)
      report($sformatf("%0d expected results never arrived", due_results.size()));

    $display("[tb] %0d transactions in (%0d not ignored), %0d results checked over 7 base_id settings",
             n_accepted, n_effective, n_results);
    $display("[tb] queued %0d held %0d popped %0d empty %0d full %0d orphan %0d ignored %0d",
             status_hits[ST_QUEUED], status_hits[ST_HELD], status_hits[ST_POPPED],
             status_hits[ST_EMPTY], status_hits[ST_FULL], status_hits[ST_NO_HDR],
             status_hits[ST_IGNORED]);
    if (n_errors == 0) $display("[can_command_frame_reassembler] OK");
    else $display("[can_command_frame_reassembler] ERROR");
    $finish;
  end

endmodule
